// ===== rtl/tcon_pkg.sv =====
package tcon_pkg;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] char_code;
    logic [4:0] target_row;
    logic [6:0] target_col;
  } tcon_in_t;

  typedef struct packed {
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic [10:0] cursor_position;
    logic        in_history_view;
    logic [15:0] cell_value;
  } tcon_out_t;

  localparam logic [2:0] OP_PUT   = 3'd0;
  localparam logic [2:0] OP_UP    = 3'd1;
  localparam logic [2:0] OP_DOWN  = 3'd2;
  localparam logic [2:0] OP_RESET = 3'd3;
  localparam logic [2:0] OP_SETC  = 3'd4;
  localparam logic [2:0] OP_CLR   = 3'd5;
  localparam logic [2:0] OP_READ  = 3'd6;
  localparam logic [2:0] OP_NOP   = 3'd7;

  localparam logic [7:0] CH_NL = 8'd10;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_BS = 8'd8;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] COLOR_RESET = 8'd7;

  typedef enum logic [3:0] {
    ST_INIT,    // blank the screen after reset
    ST_IDLE,
    ST_DECODE,  // work out what the beat needs
    ST_WRCELL,  // single cell write
    ST_RDCELL,  // single cell read, wait for data
    ST_SCROLL,  // push top row, shift rows up
    ST_SAVE,    // copy screen to saved store
    ST_SHOW,    // render history view
    ST_RESTORE, // copy saved store back
    ST_CLRROW,  // blank one row
    ST_OUT
  } tcon_state_t;

endpackage

// ===== rtl/tcon_ram.sv =====
module tcon_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/text_console_with_scrollback.sv =====
// Text console with scrollback.
// Input channel in_valid/in_stall/in_data carries one operation per beat;
// output channel out_valid/out_stall/out_data returns one status beat per
// operation (cursor, view flag, and the cell for a read). cfg_valid/cfg_ready
// writes the text colour; it is always ready. The user must see that it is
// written only when idle; the block itself does not enforce this. One
// operation at a time: in_stall is high from acceptance until the status
// beat has been registered. A scroll reads every cell once through the screen
// RAM read port and then blanks the last row. The first view-up step saves
// the screen and then renders the history view; later steps render it again,
// and leaving the view restores the saved screen. Each RAM has a single read
// port.
// After reset the block blanks the screen RAM, one cell a cycle, with in_stall
// high; text colour returns to 7.
// If the receiver stalls, the status beat is held in the output register; the
// block takes and works on the next operation, then waits until that beat goes.
module text_console_with_scrollback
  import tcon_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 80,
  parameter int SCREEN_HEIGHT = 25,
  parameter int HISTORY_DEPTH = 100
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  tcon_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output tcon_out_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [7:0] cfg_data
);

  localparam int CELLS = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int HCELLS = HISTORY_DEPTH * SCREEN_WIDTH;
  localparam int AW = $clog2(CELLS);
  localparam int HAW = $clog2(HCELLS);
  localparam int CW = $clog2(SCREEN_WIDTH);
  localparam int RW = $clog2(SCREEN_HEIGHT);
  localparam int HW = $clog2(HISTORY_DEPTH + 1);
  localparam int SW = $clog2(HISTORY_DEPTH) > 0 ? $clog2(HISTORY_DEPTH) : 1;

  tcon_state_t state, state_next;

  // architectural registers
  logic [7:0]    color;
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [SW-1:0] head;
  logic [HW-1:0] fill;
  logic [HW-1:0] vback;
  tcon_in_t      op;
  logic [15:0]   cell_q;

  // sweep counters: pos walks read addresses, rd_ok marks the data in the cycle after
  logic [AW:0]   pos;
  logic [AW-1:0] wpos;
  logic          rd_ok;
  logic [CW-1:0] sx;      // column of the sweep
  logic [RW-1:0] sy;      // row of the sweep
  logic [CW-1:0] wx;
  logic [RW-1:0] wy;
  logic [SW-1:0] slot;    // history slot of current render row
  logic          phase;   // show: 0 history rows, 1 saved rows

  logic [15:0] blank;
  assign blank = {color, CH_SPACE};

  // RAM ports
  logic scr_we, hist_we, sav_we;
  logic [AW-1:0] scr_wa, scr_ra, sav_wa, sav_ra;
  logic [HAW-1:0] hist_wa, hist_ra;
  logic [15:0] scr_wd, scr_rd, hist_rd, sav_rd, sav_wd, hist_wd;

  tcon_ram #(.WIDTH(16), .DEPTH(CELLS)) u_scr (
    .clk, .we(scr_we), .waddr(scr_wa), .wdata(scr_wd), .raddr(scr_ra), .rdata(scr_rd));
  tcon_ram #(.WIDTH(16), .DEPTH(HCELLS)) u_hist (
    .clk, .we(hist_we), .waddr(hist_wa), .wdata(hist_wd), .raddr(hist_ra),
    .rdata(hist_rd));
  tcon_ram #(.WIDTH(16), .DEPTH(CELLS)) u_sav (
    .clk, .we(sav_we), .waddr(sav_wa), .wdata(sav_wd), .raddr(sav_ra), .rdata(sav_rd));

  // saturated targets
  logic [RW-1:0] trow;
  logic [CW-1:0] tcol;
  always_comb begin
    if (32'(op.target_row) >= SCREEN_HEIGHT) trow = RW'(SCREEN_HEIGHT - 1);
    else trow = RW'(op.target_row);
    if (32'(op.target_col) >= SCREEN_WIDTH) tcol = CW'(SCREEN_WIDTH - 1);
    else tcol = CW'(op.target_col);
  end

  // row blanked by the clear pass: the target for clear line, else the last
  // row after a scroll
  logic [RW-1:0] clr_row;
  assign clr_row = (op.operation == OP_CLR) ? trow : RW'(SCREEN_HEIGHT - 1);

  // character decode
  logic [CW:0] tab_col;
  logic        wraps;
  assign tab_col = ({1'b0, col} + (CW+1)'(4)) & ~(CW+1)'(3);
  assign wraps = (32'(row) == SCREEN_HEIGHT - 1);

  // row base for a row number: multiply by a constant
  function automatic logic [AW-1:0] rbase(input logic [RW-1:0] r);
    rbase = AW'(32'(r) * SCREEN_WIDTH);
  endfunction

  logic sweep_done;
  assign sweep_done = rd_ok && (32'(wpos) == CELLS - 1);

  // ---------------- next state ----------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT: if (32'(pos) == CELLS - 1) state_next = ST_IDLE;
      ST_IDLE: if (in_valid) state_next = ST_DECODE;
      ST_DECODE: begin
        unique case (op.operation)
          OP_PUT: begin
            if (op.char_code == CH_NL) state_next = wraps ? ST_SCROLL : ST_OUT;
            else if (op.char_code == CH_TAB)
              state_next = (32'(tab_col) >= SCREEN_WIDTH && wraps) ? ST_SCROLL : ST_OUT;
            else if (op.char_code == CH_BS) state_next = (col != '0) ? ST_WRCELL : ST_OUT;
            else state_next = ST_WRCELL;
          end
          OP_UP: begin
            if (fill == '0) state_next = ST_OUT;
            else if (vback == '0) state_next = ST_SAVE;
            else state_next = ST_SHOW;
          end
          OP_DOWN: begin
            if (vback > HW'(1)) state_next = ST_SHOW;
            else if (vback != '0) state_next = ST_RESTORE;
            else state_next = ST_OUT;
          end
          OP_RESET: state_next = (vback != '0) ? ST_RESTORE : ST_OUT;
          OP_CLR: state_next = ST_CLRROW;
          OP_READ: state_next = ST_RDCELL;
          default: state_next = ST_OUT;
        endcase
      end
      ST_WRCELL: begin
        if (op.char_code != CH_BS && 32'(col) == SCREEN_WIDTH - 1 && wraps)
          state_next = ST_SCROLL;
        else state_next = ST_OUT;
      end
      ST_RDCELL: if (rd_ok) state_next = ST_OUT;
      ST_SCROLL, ST_SAVE, ST_SHOW, ST_RESTORE: if (sweep_done) state_next =
        (state == ST_SAVE) ? ST_SHOW : (state == ST_SCROLL) ? ST_CLRROW : ST_OUT;
      ST_CLRROW: if (32'(sx) == SCREEN_WIDTH - 1) state_next = ST_OUT;
      ST_OUT: if (!out_valid || !out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_INIT;
    else state <= state_next;
  end

  // ---------------- memory port control ----------------
  // Show: screen row y takes history slot (head - k + y) for y < k, else
  // saved row y - k. The read side walks sy/sx; wx/wy are the delayed copy.
  logic [AW-1:0] sav_row_addr;
  assign sav_row_addr = rbase(RW'(32'(sy) - 32'(vback))) + AW'(sx);

  always_comb begin
    scr_we = 1'b0; scr_wa = wpos; scr_wd = blank; scr_ra = pos[AW-1:0];
    hist_we = 1'b0;
    hist_wa = HAW'(32'(head) * SCREEN_WIDTH + 32'(wx));
    hist_wd = scr_rd;
    hist_ra = HAW'(32'(slot) * SCREEN_WIDTH + 32'(sx));
    sav_we = 1'b0; sav_wa = wpos; sav_wd = scr_rd;
    sav_ra = (state == ST_SHOW) ? sav_row_addr : pos[AW-1:0];
    unique case (state)
      ST_INIT: begin
        scr_we = 1'b1; scr_wa = pos[AW-1:0]; scr_wd = 16'h0720;
      end
      ST_WRCELL: begin
        scr_we = 1'b1;
        if (op.char_code == CH_BS) begin
          scr_wa = rbase(row) + AW'(col - CW'(1));
          scr_wd = blank;
        end else begin
          scr_wa = rbase(row) + AW'(col);
          scr_wd = {color, op.char_code};
        end
      end
      ST_RDCELL: scr_ra = rbase(trow) + AW'(tcol);
      ST_SCROLL: begin
        // read cell pos, write it to pos - W (or to history for top row);
        // the last row is blanked by the clear pass that follows
        if (rd_ok) begin
          if (32'(wy) == 0) hist_we = 1'b1;
          else begin
            scr_we = 1'b1; scr_wa = AW'(32'(wpos) - SCREEN_WIDTH); scr_wd = scr_rd;
          end
        end
      end
      ST_SAVE: if (rd_ok) sav_we = 1'b1;
      ST_SHOW: begin
        if (rd_ok) begin
          scr_we = 1'b1; scr_wa = wpos;
          scr_wd = phase ? sav_rd : hist_rd;
        end
      end
      ST_RESTORE: if (rd_ok) begin
        scr_we = 1'b1; scr_wa = wpos; scr_wd = sav_rd;
      end
      ST_CLRROW: begin
        scr_we = 1'b1; scr_wa = rbase(clr_row) + AW'(sx);
      end
      default: ;
    endcase
  end

  // ---------------- datapath registers ----------------
  // Scroll sweep: reads run over all CELLS; the write stage follows in the next cycle.
  // Writes of cell p go to p-W (top-row cells to history); the last row keeps its old contents until
  // the clear pass after the sweep blanks it.
  always_ff @(posedge clk) begin
    if (rst) begin
      color <= COLOR_RESET;
      col <= '0; row <= '0; head <= '0; fill <= '0; vback <= '0;
      pos <= '0; rd_ok <= 1'b0;
      sx <= '0; sy <= '0; wx <= '0; wy <= '0; wpos <= '0; phase <= 1'b0;
    end else begin
      if (cfg_valid) color <= cfg_data;
      rd_ok <= 1'b0;
      unique case (state)
        ST_INIT: pos <= pos + (AW+1)'(1);
        ST_IDLE: if (in_valid) op <= in_data;
        ST_DECODE: begin
          pos <= '0; sx <= '0; sy <= '0;
          cell_q <= '0;
          unique case (op.operation)
            OP_PUT: begin
              if (op.char_code == CH_NL) begin
                col <= '0;
                if (!wraps) row <= row + RW'(1);
              end else if (op.char_code == CH_TAB) begin
                if (32'(tab_col) >= SCREEN_WIDTH) begin
                  col <= '0;
                  if (!wraps) row <= row + RW'(1);
                end else col <= CW'(tab_col);
              end
            end
            OP_UP: if (fill != '0 && vback < fill) vback <= vback + HW'(1);
            OP_DOWN: if (vback > HW'(1)) vback <= vback - HW'(1);
            OP_SETC: begin row <= trow; col <= tcol; end
            default: ;
          endcase
          // first render slot for show after view change
          phase <= 1'b0;
        end
        ST_WRCELL: begin
          if (op.char_code == CH_BS) col <= col - CW'(1);
          else if (32'(col) == SCREEN_WIDTH - 1) begin
            col <= '0;
            if (!wraps) row <= row + RW'(1);
          end else col <= col + CW'(1);
        end
        ST_RDCELL: begin
          rd_ok <= ~rd_ok;
          if (rd_ok) cell_q <= scr_rd;
        end
        ST_CLRROW: begin
          sx <= sx + CW'(1);
          if (32'(sx) == SCREEN_WIDTH - 1) begin row <= clr_row; col <= '0; end
        end
        ST_SCROLL, ST_SAVE, ST_SHOW, ST_RESTORE: begin
          // issue reads
          if (32'(pos) < CELLS) begin
            pos <= pos + (AW+1)'(1);
            rd_ok <= 1'b1;
            wpos <= pos[AW-1:0]; wx <= sx; wy <= sy;
            if (32'(sx) == SCREEN_WIDTH - 1) begin
              sx <= '0; sy <= sy + RW'(1);
            end else sx <= sx + CW'(1);
          end
          if (state == ST_SHOW) begin
            // slot / phase follow the row being read
            phase <= (32'(sy) >= 32'(vback));
          end
          // save runs straight into show, scroll into the clear pass
          if ((state == ST_SAVE || state == ST_SCROLL) && sweep_done) begin
            pos <= '0; sx <= '0; sy <= '0;
          end
          if (state == ST_SCROLL && sweep_done) begin
            head <= (32'(head) == HISTORY_DEPTH - 1) ? '0 : head + SW'(1);
            if (32'(fill) < HISTORY_DEPTH) fill <= fill + HW'(1);
          end
          if ((state == ST_RESTORE || state == ST_SHOW) && sweep_done && state == ST_RESTORE)
            vback <= '0;
        end
        default: ;
      endcase
    end
  end

  // Show slot is computed combinationally from sy, so
  // that the read issued for row sy uses slot (head - k + sy) mod depth.
  logic [SW+HW:0] slot_sum;
  assign slot_sum = (SW+HW+1)'(head) + (SW+HW+1)'(HISTORY_DEPTH) - (SW+HW+1)'(vback)
                    + (SW+HW+1)'(sy);
  always_comb slot = (32'(slot_sum) >= HISTORY_DEPTH)
                     ? SW'(32'(slot_sum) - HISTORY_DEPTH) : SW'(slot_sum);

  // ---------------- output ----------------
  logic [RW-1:0] orow;
  always_comb orow = row;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (state == ST_OUT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
        out_data.cursor_row <= 5'(orow);
        out_data.cursor_col <= 7'(col);
        out_data.cursor_position <= 11'(32'(orow) * SCREEN_WIDTH + 32'(col));
        out_data.in_history_view <= (vback != '0);
        out_data.cell_value <= (op.operation == OP_READ) ? cell_q : 16'h0000;
      end
    end
  end

  assign in_stall = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

endmodule
